FILE: rtl/light_bar_pair_matcher_unit_macros.svh
// Assertion helpers used by the RTL.
`ifndef LIGHT_BAR_PAIR_MATCHER_UNIT_MACROS_SVH
`define LIGHT_BAR_PAIR_MATCHER_UNIT_MACROS_SVH

// Checked only outside reset.
`define LBPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LBPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lbpm_pkg.sv
package lbpm_pkg;

  localparam int MAX_BARS  = 32;
  localparam int MAX_OUT   = 16;
  localparam int IDX_W     = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int CNT_W     = $clog2(MAX_BARS + 1);
  localparam int OUT_IDX_W = 5;
  localparam int NOUT_W    = $clog2(MAX_OUT + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SLOPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ASPECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_DIFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_DIFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_DIFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEEP      = 3'd6;

  typedef struct packed {
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        length;
    logic signed [12:0] angle;
    logic [15:0]        slope;
  } bar_rec_t;

  localparam int REC_W = $bits(bar_rec_t);

endpackage

FILE: rtl/lbpm_bar_if.sv
interface lbpm_bar_if;
  logic               valid;
  logic               ready;
  logic [15:0]        center_x;
  logic [15:0]        center_y;
  logic [15:0]        side_width;
  logic [15:0]        side_height;
  logic signed [12:0] tilt;
  logic [15:0]        diag_slope;
  logic               last_bar;

  modport source (output valid, center_x, center_y, side_width, side_height, tilt,
                  diag_slope, last_bar, input ready);
  modport sink (input valid, center_x, center_y, side_width, side_height, tilt,
                diag_slope, last_bar, output ready);
endinterface

interface lbpm_pair_if;
  logic       valid;
  logic       ready;
  logic [4:0] left_index;
  logic [4:0] right_index;
  logic       pair_valid;
  logic       overflow;
  logic       last_pair;

  modport source (output valid, left_index, right_index, pair_valid, overflow,
                  last_pair, input ready);
  modport sink (input valid, left_index, right_index, pair_valid, overflow,
                last_pair, output ready);
endinterface

FILE: rtl/light_bar_pair_matcher_unit.sv
// Load: one bar per cycle while idle; a kept bar is written to the bar store the
// same cycle while the store has room. Pairing pass after the last bar: each outer
// bar is read, then each partner is skipped or tested (store read, diffs, compares).
// Each result waits for the output register to drain; the next frame is taken from
// the cycle after the final result is loaded. Synchronous active-low reset restores
// register defaults and clears count, flags and control; store data is not cleared.
`include "light_bar_pair_matcher_unit_macros.svh"

module light_bar_pair_matcher_unit
  import lbpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  lbpm_bar_if.sink             in_bar,
  lbpm_pair_if.source          out_pair
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OUTER = 3'd1;
  localparam logic [2:0] S_LATI  = 3'd2;
  localparam logic [2:0] S_JRD   = 3'd3;
  localparam logic [2:0] S_JC1   = 3'd4;
  localparam logic [2:0] S_JC2   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam int EXT_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

  logic [15:0] min_slope_r, slope_diff_r, len_diff_r;
  logic [7:0]  min_aspect_r, gap_r, steep_r;
  logic [12:0] angle_diff_r;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                dropped_r, dropped_nxt;
  logic [MAX_BARS-1:0] paired_r, paired_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [NOUT_W-1:0]   npair_r, npair_nxt;
  bar_rec_t            reci_r, reci_nxt;

  logic                pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]    pend_l_r, pend_l_nxt, pend_rt_r, pend_rt_nxt;

  logic                out_v_r, out_v_nxt;
  logic [IDX_W-1:0]    out_l_r, out_l_nxt, out_rt_r, out_rt_nxt;
  logic                out_pv_r, out_pv_nxt, out_last_r, out_last_nxt;

  logic [15:0] d_slope_r, d_len_r, maxlen_r, dx_r, dy_r;
  logic [13:0] d_ang_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  bar_rec_t         ram_wdata, ram_rdata;

  lbpm_ram #(.WIDTH(REC_W), .DEPTH(MAX_BARS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_slope_r  <= 16'd256;
      min_aspect_r <= 8'd40;
      slope_diff_r <= 16'd520;
      gap_r        <= 8'd40;
      angle_diff_r <= 13'd160;
      len_diff_r   <= 16'd240;
      steep_r      <= 8'd80;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_SLOPE:  min_slope_r  <= cfg_data;
        REG_MIN_ASPECT: min_aspect_r <= cfg_data[7:0];
        REG_SLOPE_DIFF: slope_diff_r <= cfg_data;
        REG_GAP:        gap_r        <= cfg_data[7:0];
        REG_ANGLE_DIFF: angle_diff_r <= cfg_data[12:0];
        REG_LEN_DIFF:   len_diff_r   <= cfg_data;
        REG_STEEP:      steep_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // bar filter
  logic [15:0] lng, sht;
  logic        keep, in_fire;
  assign lng     = (in_bar.side_width > in_bar.side_height) ? in_bar.side_width
                                                             : in_bar.side_height;
  assign sht     = (in_bar.side_width > in_bar.side_height) ? in_bar.side_height
                                                             : in_bar.side_width;
  assign keep    = (in_bar.diag_slope > min_slope_r) &&
                   ({lng, 4'b0} > (24'(min_aspect_r) * 24'(sht)));
  assign in_fire = in_bar.valid && in_bar.ready;
  assign in_bar.ready = (state_r == S_IDLE);

  assign ram_we    = in_fire && keep && (cnt_r < CNT_W'(MAX_BARS));
  assign ram_wdata = '{x: in_bar.center_x, y: in_bar.center_y, length: lng,
                       angle: in_bar.tilt, slope: in_bar.diag_slope};

  // pair tests
  bar_rec_t    rj;
  logic signed [13:0] ang_d;
  logic        pair_ok;
  assign rj    = ram_rdata;
  assign ang_d = 14'(reci_r.angle) - 14'(rj.angle);
  assign pair_ok = !(d_slope_r > slope_diff_r) &&
                   !({dx_r, 4'b0} > (24'(gap_r) * 24'(maxlen_r))) &&
                   !(d_ang_r > 14'(angle_diff_r)) &&
                   !(d_len_r > len_diff_r) &&
                   !({dy_r, 4'b0} > (24'(steep_r) * 24'(dx_r))) &&
                   !(dy_r > maxlen_r);

  always_ff @(posedge clk) begin
    if (state_r == S_JC1) begin
      d_slope_r <= (reci_r.slope > rj.slope) ? reci_r.slope - rj.slope
                                             : rj.slope - reci_r.slope;
      d_len_r   <= (reci_r.length > rj.length) ? reci_r.length - rj.length
                                               : rj.length - reci_r.length;
      maxlen_r  <= (reci_r.length > rj.length) ? reci_r.length : rj.length;
      dx_r      <= (reci_r.x > rj.x) ? reci_r.x - rj.x : rj.x - reci_r.x;
      dy_r      <= (reci_r.y > rj.y) ? reci_r.y - rj.y : rj.y - reci_r.y;
      d_ang_r   <= ang_d[13] ? 14'(-ang_d) : 14'(ang_d);
    end
  end

  logic j_last, i_has_next;
  assign j_last     = (CNT_W'(j_r) + CNT_W'(1)) >= cnt_r;
  assign i_has_next = (CNT_W'(i_r) + CNT_W'(1)) < cnt_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    dropped_nxt  = dropped_r;
    paired_nxt   = paired_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    npair_nxt    = npair_r;
    reci_nxt     = reci_r;
    pend_v_nxt   = pend_v_r;
    pend_l_nxt   = pend_l_r;
    pend_rt_nxt  = pend_rt_r;
    out_v_nxt    = out_v_r && !out_pair.ready;
    out_l_nxt    = out_l_r;
    out_rt_nxt   = out_rt_r;
    out_pv_nxt   = out_pv_r;
    out_last_nxt = out_last_r;
    ram_raddr    = i_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (keep) begin
            if (cnt_r < CNT_W'(MAX_BARS)) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              dropped_nxt = 1'b1;
            end
          end
          if (in_bar.last_bar) begin
            i_nxt     = '0;
            state_nxt = S_OUTER;
          end
        end
      end
      S_OUTER: begin
        if (!i_has_next || npair_r == NOUT_W'(MAX_OUT)) begin
          state_nxt = S_DONE;
        end else if (paired_r[i_r]) begin
          i_nxt = i_r + IDX_W'(1);
        end else begin
          ram_raddr = i_r;
          j_nxt     = i_r + IDX_W'(1);
          state_nxt = S_LATI;
        end
      end
      S_LATI: begin
        reci_nxt  = ram_rdata;
        state_nxt = S_JRD;
      end
      S_JRD: begin
        ram_raddr = j_r;
        if (paired_r[j_r]) begin
          if (j_last) begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_OUTER;
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          state_nxt = S_JC1;
        end
      end
      S_JC1: begin
        state_nxt = S_JC2;
      end
      S_JC2: begin
        if (pair_ok) begin
          // previous pair is known not to be final; push it out first
          if (!out_v_r) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_l_nxt    = pend_l_r;
              out_rt_nxt   = pend_rt_r;
              out_pv_nxt   = 1'b1;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt       = 1'b1;
            pend_l_nxt       = i_r;
            pend_rt_nxt      = j_r;
            paired_nxt[i_r]  = 1'b1;
            paired_nxt[j_r]  = 1'b1;
            npair_nxt        = npair_r + NOUT_W'(1);
            i_nxt            = i_r + IDX_W'(1);
            state_nxt        = S_OUTER;
          end
        end else if (j_last) begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_OUTER;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_JRD;
        end
      end
      S_DONE: begin
        if (!out_v_r) begin
          out_v_nxt    = 1'b1;
          out_l_nxt    = pend_v_r ? pend_l_r : '0;
          out_rt_nxt   = pend_v_r ? pend_rt_r : '0;
          out_pv_nxt   = pend_v_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          npair_nxt    = '0;
          paired_nxt   = '0;
          cnt_nxt      = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // overflow is sampled when each result is loaded
  logic out_ovf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
      paired_r  <= '0;
      npair_r   <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      dropped_r <= (state_r == S_DONE && !out_v_r) ? 1'b0 : dropped_nxt;
      paired_r  <= paired_nxt;
      npair_r   <= npair_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    reci_r     <= reci_nxt;
    pend_l_r   <= pend_l_nxt;
    pend_rt_r  <= pend_rt_nxt;
    out_l_r    <= out_l_nxt;
    out_rt_r   <= out_rt_nxt;
    out_pv_r   <= out_pv_nxt;
    out_last_r <= out_last_nxt;
    if (out_v_nxt && !out_v_r) begin
      out_ovf_r <= dropped_r;
    end
  end

  logic [EXT_W-1:0] out_l_ext, out_rt_ext;
  assign out_l_ext  = EXT_W'(out_l_r);
  assign out_rt_ext = EXT_W'(out_rt_r);

  assign out_pair.valid       = out_v_r;
  assign out_pair.left_index  = out_l_ext[OUT_IDX_W-1:0];
  assign out_pair.right_index = out_rt_ext[OUT_IDX_W-1:0];
  assign out_pair.pair_valid  = out_pv_r;
  assign out_pair.overflow    = out_ovf_r;
  assign out_pair.last_pair   = out_last_r;

  `LBPM_ASSERT(a_cnt_range, cnt_r <= CNT_W'(MAX_BARS), "bar count beyond store size")
  `LBPM_ASSERT(a_npair_range, npair_r <= NOUT_W'(MAX_OUT), "too many pairs in frame")
  `LBPM_ASSERT(a_marker_last, (out_v_r && !out_pv_r) |-> out_last_r, "end marker not final")
  `LBPM_ASSERT(a_frame_clear, (state_r == S_DONE && !out_v_r) |=> (cnt_r == '0 && !pend_v_r), "frame state not cleared")
  `LBPM_ASSERT(a_out_hold, (out_v_r && !out_pair.ready) |=> (out_v_r && $stable(out_last_r)), "result dropped while stalled")

endmodule

FILE: rtl/lbpm_ram.sv
module lbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: test/tb.sv
module tb;
  import lbpm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic signed [12:0] tilt;
    logic [15:0]        slope;
    logic               last;
  } bar_t;

  typedef struct {
    logic [4:0] left;
    logic [4:0] right;
    logic       pv;
    logic       ov;
    logic       lp;
  } pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  lbpm_bar_if  bar_ch ();
  lbpm_pair_if pair_ch ();

  light_bar_pair_matcher_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_bar(bar_ch), .out_pair(pair_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // predictor state
  logic [15:0]        thr_slope, slope_diff, len_diff;
  logic [7:0]         thr_aspect, gap_k, steep_k;
  logic [12:0]        ang_diff;
  logic [15:0]        st_x [MAX_BARS];
  logic [15:0]        st_y [MAX_BARS];
  logic [15:0]        st_len [MAX_BARS];
  logic signed [12:0] st_ang [MAX_BARS];
  logic [15:0]        st_slope [MAX_BARS];
  bit                 taken [MAX_BARS];
  int                 n_bars;
  bit                 dropped;

  bar_t  bar_q [$];
  pair_t pair_q [$];
  bar_t  cur;
  bit    sent;
  int    bars_left;
  int    burst_left, gap_left;
  int    hold_left, cyc, pairs_seen;
  bit    long_hold_done;
  int    fails;

  // pairing geometry of store entries a and b
  function automatic bit pair_fits(int a, int b);
    longint unsigned maxlen, dx, dy, ds, dl;
    int da;
    maxlen = (st_len[a] > st_len[b]) ? st_len[a] : st_len[b];
    dx = (st_x[a] > st_x[b]) ? st_x[a] - st_x[b] : st_x[b] - st_x[a];
    dy = (st_y[a] > st_y[b]) ? st_y[a] - st_y[b] : st_y[b] - st_y[a];
    ds = (st_slope[a] > st_slope[b]) ? st_slope[a] - st_slope[b]
                                     : st_slope[b] - st_slope[a];
    dl = (st_len[a] > st_len[b]) ? st_len[a] - st_len[b] : st_len[b] - st_len[a];
    da = int'(st_ang[a]) - int'(st_ang[b]);
    if (da < 0) da = -da;
    if (ds > slope_diff) return 0;
    if (dx * 16 > longint'(gap_k) * maxlen) return 0;
    if (da > int'(ang_diff)) return 0;
    if (dl > len_diff) return 0;
    if (dy * 16 > longint'(steep_k) * dx) return 0;
    if (dy > maxlen) return 0;
    return 1;
  endfunction

  task automatic predict_pairs(bar_t b);
    logic [15:0] lng, sht;
    int n;
    pair_t p;
    lng = (b.w > b.h) ? b.w : b.h;
    sht = (b.w > b.h) ? b.h : b.w;
    n = 0;
    if (b.slope > thr_slope && longint'(lng) * 16 > longint'(thr_aspect) * sht) begin
      if (n_bars < MAX_BARS) begin
        st_x[n_bars] = b.cx;
        st_y[n_bars] = b.cy;
        st_len[n_bars] = lng;
        st_ang[n_bars] = b.tilt;
        st_slope[n_bars] = b.slope;
        taken[n_bars] = 0;
        n_bars++;
      end else begin
        dropped = 1;
      end
    end
    if (!b.last) return;
    for (int i = 0; i + 1 < n_bars && n < MAX_OUT; i++) begin
      if (taken[i]) continue;
      for (int j = i + 1; j < n_bars; j++) begin
        if (!taken[j] && pair_fits(i, j)) begin
          taken[i] = 1;
          taken[j] = 1;
          p.left = i[4:0];
          p.right = j[4:0];
          p.pv = 1'b1;
          p.ov = dropped;
          p.lp = 1'b0;
          pair_q = {pair_q, p};
          n++;
          break;
        end
      end
    end
    if (n == 0) begin
      p.left = '0;
      p.right = '0;
      p.pv = 1'b0;
      p.ov = dropped;
      p.lp = 1'b1;
      pair_q = {pair_q, p};
    end else begin
      pair_q[pair_q.size() - 1].lp = 1'b1;
    end
    for (int k = 0; k < MAX_BARS; k++) taken[k] = 0;
    n_bars = 0;
    dropped = 0;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst_n && bar_ch.valid && bar_ch.ready) begin
      predict_pairs(cur);
      bars_left--;
      sent = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      bar_ch.valid <= 1'b0;
    end else if (!bar_ch.valid || sent) begin
      sent = 0;
      if (gap_left > 0) begin
        gap_left--;
        bar_ch.valid <= 1'b0;
      end else if (bar_q.size() > 0) begin
        cur = bar_q.pop_front();
        bar_ch.center_x <= cur.cx;
        bar_ch.center_y <= cur.cy;
        bar_ch.side_width <= cur.w;
        bar_ch.side_height <= cur.h;
        bar_ch.tilt <= cur.tilt;
        bar_ch.diag_slope <= cur.slope;
        bar_ch.last_bar <= cur.last;
        bar_ch.valid <= 1'b1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        bar_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, quiet windows, one long hold-off
  always @(negedge clk) begin
    cyc++;
    if (!rst_n) begin
      pair_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pair_ch.ready <= 1'b0;
    end else if (pairs_seen >= 30 && !long_hold_done) begin
      long_hold_done = 1;
      hold_left = 400;
      pair_ch.ready <= 1'b0;
    end else if (cyc[7:6] == 2'd0) begin
      pair_ch.ready <= 1'b1;
    end else begin
      pair_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    pair_t e;
    if (rst_n && pair_ch.valid && pair_ch.ready) begin
      pairs_seen++;
      if (pair_q.size() == 0) begin
        $error("unexpected result: left_index %0d right_index %0d",
               pair_ch.left_index, pair_ch.right_index);
        fails++;
      end else begin
        e = pair_q.pop_front();
        if (pair_ch.left_index !== e.left) begin
          $error("left_index: expected %0d, got %0d", e.left, pair_ch.left_index);
          fails++;
        end
        if (pair_ch.right_index !== e.right) begin
          $error("right_index: expected %0d, got %0d", e.right, pair_ch.right_index);
          fails++;
        end
        if (pair_ch.pair_valid !== e.pv) begin
          $error("pair_valid: expected %0d, got %0d", e.pv, pair_ch.pair_valid);
          fails++;
        end
        if (pair_ch.overflow !== e.ov) begin
          $error("overflow: expected %0d, got %0d", e.ov, pair_ch.overflow);
          fails++;
        end
        if (pair_ch.last_pair !== e.lp) begin
          $error("last_pair: expected %0d, got %0d", e.lp, pair_ch.last_pair);
          fails++;
        end
      end
    end
  end

  task automatic push_bar(logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                          logic [15:0] h, logic signed [12:0] t, logic [15:0] s,
                          logic last);
    bar_t b;
    b.cx = cx; b.cy = cy; b.w = w; b.h = h; b.tilt = t; b.slope = s; b.last = last;
    bar_q = {bar_q, b};
    bars_left++;
  endtask

  function automatic logic signed [12:0] rand_tilt();
    return 13'(int'($urandom_range(0, 5760)) - 2880);
  endfunction

  // bars that tend to pair, mixed with noise bars
  task automatic push_frame(int n, int noise_pct);
    int x, y, len, s, t, l;
    x = $urandom_range(0, 20000);
    y = $urandom_range(2000, 60000);
    len = $urandom_range(50, 3000);
    s = $urandom_range(0, 65000);
    t = $urandom_range(0, 5000) - 2500;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_bar(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 rand_tilt(), 16'($urandom), k == n - 1);
      end else begin
        x += $urandom_range(0, 2 * len);
        if (x > 65535) x = 65535;
        l = len + $urandom_range(0, 200) - 100;
        if (l < 1) l = 1;
        if ($urandom_range(0, 1))
          push_bar(16'(x), 16'(y + $urandom_range(0, 400) - 200), 16'(l),
                   16'(l / $urandom_range(3, 6)),
                   13'(t + $urandom_range(0, 200) - 100),
                   16'(s + $urandom_range(0, 500)), k == n - 1);
        else
          push_bar(16'(x), 16'(y + $urandom_range(0, 400) - 200),
                   16'(l / $urandom_range(3, 6)), 16'(l),
                   13'(t + $urandom_range(0, 200) - 100),
                   16'(s + $urandom_range(0, 500)), k == n - 1);
      end
    end
  endtask

  // 40 identical bars: store fills, 16 pairs at most
  task automatic push_full_frame();
    for (int k = 0; k < 40; k++) push_bar(16'd1000, 16'd1000, 16'd800, 16'd100,
                                          13'sd0, 16'd65000, k == 39);
  endtask

  task automatic push_random_frames(int budget);
    int target;
    target = bars_left + budget;
    while (bars_left < target) begin
      if ($urandom_range(0, 15) == 0) push_frame($urandom_range(33, 40), 10);
      else push_frame($urandom_range(1, 12), $urandom_range(0, 30));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bars_left > 0 || pair_q.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MIN_SLOPE:  thr_slope = val;
      REG_MIN_ASPECT: thr_aspect = val[7:0];
      REG_SLOPE_DIFF: slope_diff = val;
      REG_GAP:        gap_k = val[7:0];
      REG_ANGLE_DIFF: ang_diff = val[12:0];
      REG_LEN_DIFF:   len_diff = val;
      REG_STEEP:      steep_k = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int ms, int ma, int sd, int gf, int ad, int ld, int sf);
    write_reg(REG_MIN_SLOPE, CFG_DAT_W'(ms));
    write_reg(REG_MIN_ASPECT, CFG_DAT_W'(ma));
    write_reg(REG_SLOPE_DIFF, CFG_DAT_W'(sd));
    write_reg(REG_GAP, CFG_DAT_W'(gf));
    write_reg(REG_ANGLE_DIFF, CFG_DAT_W'(ad));
    write_reg(REG_LEN_DIFF, CFG_DAT_W'(ld));
    write_reg(REG_STEEP, CFG_DAT_W'(sf));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    bar_ch.valid = 1'b0;
    bar_ch.center_x = '0;
    bar_ch.center_y = '0;
    bar_ch.side_width = '0;
    bar_ch.side_height = '0;
    bar_ch.tilt = '0;
    bar_ch.diag_slope = '0;
    bar_ch.last_bar = 1'b0;
    pair_ch.ready = 1'b0;
    thr_slope = 16'd256; thr_aspect = 8'd40; slope_diff = 16'd520; gap_k = 8'd40;
    ang_diff = 13'd160; len_diff = 16'd240; steep_k = 8'd80;
    n_bars = 0; dropped = 0; sent = 0; bars_left = 0; burst_left = 1; gap_left = 0;
    hold_left = 0; cyc = 0; pairs_seen = 0; long_hold_done = 0; fails = 0;
    for (int k = 0; k < MAX_BARS; k++) taken[k] = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset thresholds
    push_bar(16'd100, 16'd100, 16'd0, 16'd0, 13'sd0, 16'd1000, 1'b1);       // both sides zero
    push_bar(16'd0, 16'd0, 16'd0, 16'd0, 13'sd0, 16'd0, 1'b1);              // nothing stored
    push_bar(16'd500, 16'd700, 16'd600, 16'd0, 13'sd10, 16'd900, 1'b0);     // zero short side
    push_bar(16'd500, 16'd700, 16'd0, 16'd600, 13'sd20, 16'd1000, 1'b1);    // dx = dy = 0
    push_bar(16'd500, 16'd700, 16'd600, 16'd10, 13'sd0, 16'd900, 1'b0);
    push_bar(16'd500, 16'd716, 16'd600, 16'd10, 13'sd0, 16'd900, 1'b1);     // dx 0, dy > 0
    push_bar(16'd0, 16'd0, 16'hFFFF, 16'd0, -13'sd2880, 16'hFFFF, 1'b0);
    push_bar(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 13'sd2880, 16'hFFFF, 1'b0);
    push_bar(16'd40000, 16'd20000, 16'd257, 16'd256, 13'sd0, 16'd257, 1'b1);
    push_random_frames(60);
    wait_drained();

    // wide open thresholds, plus a write to an unused index
    write_all(0, 0, 65535, 255, 5760, 65535, 255);
    write_reg(REG_UNUSED, 16'h0000);
    @(negedge clk);
    cfg_we <= 1'b0;
    push_full_frame();
    push_bar(16'd0, 16'd0, 16'd1, 16'd0, -13'sd2880, 16'd1, 1'b0);
    push_bar(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 13'sd2880, 16'hFFFF, 1'b1);
    push_random_frames(50);
    wait_drained();

    // everything rejected
    write_all(65535, 255, 0, 0, 0, 0, 0);
    push_random_frames(30);
    wait_drained();

    // zero tolerances but bars kept
    write_all(0, 0, 0, 0, 0, 0, 0);
    push_full_frame();
    push_random_frames(30);
    wait_drained();

    repeat (4) begin
      write_all($urandom_range(0, 2000), $urandom_range(0, 100), $urandom_range(0, 65535),
                $urandom, $urandom_range(0, 5760), $urandom_range(0, 65535), $urandom);
      push_random_frames(30);
      wait_drained();
    end

    write_all(256, 40, 520, 40, 160, 240, 80);
    push_random_frames(40);
    wait_drained();
    repeat (50) @(negedge clk);

    if (fails == 0 && pair_q.size() == 0)
      $display("light_bar_pair_matcher_unit: match");
    else
      $display("light_bar_pair_matcher_unit: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("light_bar_pair_matcher_unit: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lbpm_pkg.sv
rtl/lbpm_bar_if.sv
rtl/lbpm_ram.sv
rtl/light_bar_pair_matcher_unit.sv
test/tb.sv
